@@ hw/rtl/ills_pkg.sv @@
package ills_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 9;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 9;

    localparam logic [OP_W-1:0] OP_GET      = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_GETV,
        S_FREE,
        S_INS,
        S_INS2,
        S_DEL0,
        S_DEL1,
        S_DEL2,
        S_DEL3
    } t_state;

endpackage

@@ hw/rtl/ills_node_store.sv @@
module ills_node_store
    import ills_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [$clog2(CAPACITY)-1:0] i_link_rd_addr,
    output logic [$clog2(CAPACITY)-1:0] o_link_rd_data,
    input  logic                        i_link_we,
    input  logic [$clog2(CAPACITY)-1:0] i_link_wr_addr,
    input  logic [$clog2(CAPACITY)-1:0] i_link_wr_data,
    input  logic [$clog2(CAPACITY)-1:0] i_val_rd_addr,
    output logic [VAL_W-1:0]            o_val_rd_data,
    input  logic                        i_val_we,
    input  logic [$clog2(CAPACITY)-1:0] i_val_wr_addr,
    input  logic [VAL_W-1:0]            i_val_wr_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [IW-1:0]    link_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem  [CAPACITY];

    logic [IW-1:0] r_link_rd;
    logic [IW-1:0] r_rd_addr;
    logic          r_rd_virgin;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;

    // entries at or above the fill mark were never written: link reads as index plus one
    always_comb begin
        n_fill = r_fill;
        if (i_link_we && (CW'(i_link_wr_addr) >= r_fill)) begin
            n_fill = r_fill + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            link_mem[i_link_wr_addr] <= i_link_wr_data;
        end
        r_link_rd   <= link_mem[i_link_rd_addr];
        r_rd_addr   <= i_link_rd_addr;
        r_rd_virgin <= (CW'(i_link_rd_addr) >= r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            val_mem[i_val_wr_addr] <= i_val_wr_data;
        end
        o_val_rd_data <= val_mem[i_val_rd_addr];
    end

    always_comb begin
        if (r_rd_virgin) begin
            o_link_rd_data = (r_rd_addr == IW'(CAPACITY - 1)) ? '0 : r_rd_addr + IW'(1);
        end else begin
            o_link_rd_data = r_link_rd;
        end
    end

endmodule

@@ hw/rtl/indexed_linked_list_store_core.sv @@
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------------
// command   | in        | start high, busy low      | i_operation, i_position, i_value
// result    | out       | o_result_strobe, 1 cycle  | o_read_value, o_status, o_list_length
//
// errors and unused operation codes give their result in the cycle after the accept; a get at
// position p walks the links from the head, one link memory read per step, as does an insert or
// delete at position p > 0; an insert or delete at the head needs no walk.
// synchronous active-low reset empties the list at once; no clearing pass over the memories.
// busy is high while a transaction is in progress; the receiver cannot stall the result.
module indexed_linked_list_store_core
    import ills_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_result_strobe,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [ST_W-1:0]         o_status,
    output logic [LEN_W-1:0]        o_list_length
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (POS_W > CW) ? POS_W : CW;

    t_state r_state, n_state;
    logic [OP_W-1:0]         r_op, n_op;
    logic [KW-1:0]           r_k, n_k;
    logic [VAL_W-1:0]        r_val, n_val;
    logic [KW-1:0]           r_left, n_left;
    logic                    r_at_head, n_at_head;
    logic [IW-1:0]           r_ptr, n_ptr;
    logic [IW-1:0]           r_head, n_head;
    logic [IW-1:0]           r_free, n_free;
    logic [IW-1:0]           r_nfree, n_nfree;
    logic [IW-1:0]           r_vic, n_vic;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_strobe, n_strobe;
    logic signed [VAL_W-1:0] r_rd_value, n_rd_value;
    logic [ST_W-1:0]         r_status, n_status;
    logic [LEN_W-1:0]        r_length, n_length;

    logic [IW-1:0]    link_rd_addr;
    logic [IW-1:0]    link_q;
    logic             link_we;
    logic [IW-1:0]    link_wa;
    logic [IW-1:0]    link_wd;
    logic [IW-1:0]    val_rd_addr;
    logic [VAL_W-1:0] val_q;
    logic             val_we;
    logic [IW-1:0]    cur;
    logic [KW-1:0]    pos_ext;
    logic [KW-1:0]    cnt_ext;
    logic [KW-1:0]    k_sel;
    logic             full;

    ills_node_store #(
        .CAPACITY(CAPACITY)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_link_rd_addr(link_rd_addr),
        .o_link_rd_data(link_q),
        .i_link_we     (link_we),
        .i_link_wr_addr(link_wa),
        .i_link_wr_data(link_wd),
        .i_val_rd_addr (val_rd_addr),
        .o_val_rd_data (val_q),
        .i_val_we      (val_we),
        .i_val_wr_addr (r_free),
        .i_val_wr_data (r_val)
    );

    assign pos_ext = KW'(i_position);
    assign cnt_ext = KW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign cur     = r_at_head ? r_head : link_q;

    always_comb begin
        case (i_operation)
            OP_ADD_HEAD: k_sel = '0;
            OP_ADD_TAIL: k_sel = cnt_ext;
            default:     k_sel = pos_ext;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_k        = r_k;
        n_val      = r_val;
        n_left     = r_left;
        n_at_head  = r_at_head;
        n_ptr      = r_ptr;
        n_head     = r_head;
        n_free     = r_free;
        n_nfree    = r_nfree;
        n_vic      = r_vic;
        n_count    = r_count;
        n_strobe   = 1'b0;
        n_rd_value = r_rd_value;
        n_status   = r_status;
        n_length   = r_length;

        link_rd_addr = r_ptr;
        link_we      = 1'b0;
        link_wa      = r_ptr;
        link_wd      = r_free;
        val_rd_addr  = r_ptr;
        val_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op       = i_operation;
                    n_val      = i_value;
                    n_k        = k_sel;
                    n_rd_value = '0;
                    n_status   = ST_OK;
                    n_length   = LEN_W'(r_count);
                    case (i_operation)
                        OP_GET: begin
                            if (pos_ext >= cnt_ext) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                n_left    = pos_ext;
                                n_at_head = 1'b1;
                                n_state   = S_WALK;
                            end
                        end
                        OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_AT: begin
                            if ((i_operation == OP_ADD_AT) && (pos_ext > cnt_ext)) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                link_rd_addr = r_free;
                                n_state      = S_FREE;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else if (pos_ext == '0) begin
                                link_rd_addr = r_head;
                                n_state      = S_DEL0;
                            end else begin
                                n_left    = pos_ext - KW'(1);
                                n_at_head = 1'b1;
                                n_state   = S_WALK;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                link_rd_addr = cur;
                val_rd_addr  = cur;
                n_at_head    = 1'b0;
                if (r_left == '0) begin
                    n_ptr = cur;
                    if (r_op == OP_GET) begin
                        n_state = S_GETV;
                    end else if (r_op == OP_DELETE) begin
                        n_state = S_DEL1;
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_left = r_left - KW'(1);
                end
            end
            S_GETV: begin
                n_strobe   = 1'b1;
                n_rd_value = val_q;
                n_state    = S_IDLE;
            end
            S_FREE: begin
                n_nfree = link_q;
                if (r_k == '0) begin
                    link_we  = 1'b1;
                    link_wa  = r_free;
                    link_wd  = r_head;
                    val_we   = 1'b1;
                    n_head   = r_free;
                    n_free   = link_q;
                    n_count  = r_count + CW'(1);
                    n_strobe = 1'b1;
                    n_length = LEN_W'(n_count);
                    n_state  = S_IDLE;
                end else begin
                    n_left    = r_k - KW'(1);
                    n_at_head = 1'b1;
                    n_state   = S_WALK;
                end
            end
            S_INS: begin
                link_we = 1'b1;
                link_wa = r_free;
                link_wd = link_q;
                val_we  = 1'b1;
                n_state = S_INS2;
            end
            S_INS2: begin
                link_we  = 1'b1;
                link_wa  = r_ptr;
                link_wd  = r_free;
                n_free   = r_nfree;
                n_count  = r_count + CW'(1);
                n_strobe = 1'b1;
                n_length = LEN_W'(n_count);
                n_state  = S_IDLE;
            end
            S_DEL0: begin
                link_we  = 1'b1;
                link_wa  = r_head;
                link_wd  = r_free;
                n_head   = link_q;
                n_free   = r_head;
                n_count  = r_count - CW'(1);
                n_strobe = 1'b1;
                n_length = LEN_W'(n_count);
                n_state  = S_IDLE;
            end
            S_DEL1: begin
                n_vic        = link_q;
                link_rd_addr = link_q;
                n_state      = S_DEL2;
            end
            S_DEL2: begin
                link_we = 1'b1;
                link_wa = r_ptr;
                link_wd = link_q;
                n_state = S_DEL3;
            end
            S_DEL3: begin
                link_we  = 1'b1;
                link_wa  = r_vic;
                link_wd  = r_free;
                n_free   = r_vic;
                n_count  = r_count - CW'(1);
                n_strobe = 1'b1;
                n_length = LEN_W'(n_count);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_free    <= '0;
            r_count   <= '0;
            r_strobe  <= 1'b0;
            r_at_head <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_free    <= n_free;
            r_count   <= n_count;
            r_strobe  <= n_strobe;
            r_at_head <= n_at_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_k        <= n_k;
        r_val      <= n_val;
        r_left     <= n_left;
        r_ptr      <= n_ptr;
        r_nfree    <= n_nfree;
        r_vic      <= n_vic;
        r_rd_value <= n_rd_value;
        r_status   <= n_status;
        r_length   <= n_length;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_read_value    = r_rd_value;
    assign o_status        = r_status;
    assign o_list_length   = r_length;

endmodule

@@ tb/sv/ills_checker.sv @@
module ills_checker
    import ills_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    o_result_strobe,
    input  logic signed [VAL_W-1:0] o_read_value,
    input  logic [ST_W-1:0]         o_status,
    input  logic [LEN_W-1:0]        o_list_length,
    output int                      fail_count,
    output int                      outstanding
);

    localparam int DEPTH = 256;

    typedef struct packed {
        logic [VAL_W-1:0] rd;
        logic [ST_W-1:0]  st;
        logic [LEN_W-1:0] len;
    } list_result_t;

    logic [VAL_W-1:0] node_data [DEPTH];
    logic [7:0]       next_node [DEPTH];
    logic [7:0]       head_node;
    logic [7:0]       free_node;
    logic [LEN_W-1:0] list_len;
    list_result_t     expected_q [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic logic [7:0] walk_links(int unsigned steps);
        logic [7:0] p;
        p = head_node;
        for (int unsigned k = 0; k < steps; k++) begin
            p = next_node[p];
        end
        return p;
    endfunction

    function automatic void link_in(int unsigned pos, logic [VAL_W-1:0] v);
        logic [7:0] n;
        logic [7:0] prev;
        n = free_node;
        free_node = next_node[n];
        node_data[n] = v;
        if (pos == 0) begin
            next_node[n] = head_node;
            head_node = n;
        end else begin
            prev = walk_links(pos - 1);
            next_node[n] = next_node[prev];
            next_node[prev] = n;
        end
        list_len++;
    endfunction

    function automatic void unlink(int unsigned pos);
        logic [7:0] victim;
        logic [7:0] prev;
        if (pos == 0) begin
            victim = head_node;
            head_node = next_node[victim];
        end else begin
            prev = walk_links(pos - 1);
            victim = next_node[prev];
            next_node[prev] = next_node[victim];
        end
        next_node[victim] = free_node;
        free_node = victim;
        list_len--;
    endfunction

    function automatic void clear_list();
        for (int k = 0; k < DEPTH; k++) begin
            node_data[k] = '0;
            next_node[k] = 8'(k + 1);
        end
        head_node = '0;
        free_node = '0;
        list_len  = '0;
    endfunction

    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] val);
        list_result_t r;
        logic         full;
        r = '0;
        r.st = ST_OK;
        full = (list_len == DEPTH);
        case (op)
            OP_GET: begin
                if (pos >= list_len) r.st = ST_RANGE;
                else r.rd = node_data[walk_links(pos)];
            end
            OP_ADD_HEAD: begin
                if (full) r.st = ST_FULL;
                else link_in(0, val);
            end
            OP_ADD_TAIL: begin
                if (full) r.st = ST_FULL;
                else link_in(list_len, val);
            end
            OP_ADD_AT: begin
                if (pos > list_len) r.st = ST_RANGE;
                else if (full) r.st = ST_FULL;
                else link_in(pos, val);
            end
            OP_DELETE: begin
                if (pos >= list_len) r.st = ST_RANGE;
                else unlink(pos);
            end
            default: ;
        endcase
        r.len = list_len;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        list_result_t want;
        if (!i_rst_n) begin
            clear_list();
            expected_q.delete();
        end else begin
            if (start && !busy) begin
                expected_q.push_back(apply_list_op(i_operation, i_position, i_value));
            end
            if (o_result_strobe) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $error("result transaction with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    if (o_read_value !== want.rd) begin
                        fail_count++;
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.rd), o_read_value);
                    end
                    if (o_status !== want.st) begin
                        fail_count++;
                        $error("status: expected %0d, got %0d", want.st, o_status);
                    end
                    if (o_list_length !== want.len) begin
                        fail_count++;
                        $error("list_length: expected %0d, got %0d",
                               want.len, o_list_length);
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

@@ tb/sv/indexed_linked_list_store_core_tb.sv @@
module indexed_linked_list_store_core_tb;
    import ills_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int FULL_LEN   = 256;
    localparam int N_RANDOM   = 560;
    localparam int SHRINK_LEN = 150;
    localparam int HOLD_ITEMS = 14;

    typedef enum int {GROW, HOLD_FULL, SHRINK, MIXED} fill_phase_t;
    typedef enum int {K_GET, K_DEL, K_HEAD, K_TAIL, K_AT, K_STRAY, K_SPARE} item_kind_t;

    // per phase: get, delete, add head, add tail, add at, out of range, unused code
    localparam int KIND_WEIGHT [4][7] = '{
        '{ 5,  3, 26, 28, 34, 3, 1},
        '{20,  5, 22, 22, 21, 9, 1},
        '{10, 68,  5,  4,  5, 6, 2},
        '{25, 25, 12, 12, 14, 9, 3}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         cmd_op;
    logic [POS_W-1:0]        cmd_pos;
    logic signed [VAL_W-1:0] cmd_val;
    logic                    o_result_strobe;
    logic signed [VAL_W-1:0] o_read_value;
    logic [ST_W-1:0]         o_status;
    logic [LEN_W-1:0]        o_list_length;

    int mismatches;
    int pending;
    int seen_len;
    int idle_pct = 38;
    int issued   = 0;

    always #5 i_clk = ~i_clk;

    indexed_linked_list_store_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (cmd_op),
        .i_position      (cmd_pos),
        .i_value         (cmd_val),
        .o_result_strobe (o_result_strobe),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_list_length   (o_list_length)
    );

    ills_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (cmd_op),
        .i_position      (cmd_pos),
        .i_value         (cmd_val),
        .o_result_strobe (o_result_strobe),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_list_length   (o_list_length),
        .fail_count      (mismatches),
        .outstanding     (pending)
    );

    // list length as last reported, used only to steer the stimulus
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seen_len <= 0;
        end else if (o_result_strobe) begin
            seen_len <= o_list_length;
        end
    end

    initial begin
        #10_000_000;
        $display("indexed_linked_list_store_core regression: fail");
        $finish;
    end

    task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start   <= 1'b1;
        cmd_op  <= op;
        cmd_pos <= pos;
        cmd_val <= val;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        issued++;
        idle_pct = (issued < 190) ? 38 : (issued < 380) ? 82 : 0;
    endtask

    function automatic logic [POS_W-1:0] any_pos(int len);
        return (len == 0) ? '0 : POS_W'($urandom_range(0, len - 1));
    endfunction

    task automatic next_item(input fill_phase_t phase, output logic [OP_W-1:0] op,
                             output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] val);
        int         len;
        int         r;
        int         acc;
        int         cat;
        item_kind_t kind;
        len = seen_len;
        val = $urandom;
        pos = POS_W'($urandom_range(0, FULL_LEN));
        r   = $urandom_range(99);
        cat = 0;
        acc = KIND_WEIGHT[phase][0];
        while (r >= acc) begin
            cat++;
            acc += KIND_WEIGHT[phase][cat];
        end
        kind = item_kind_t'(cat);
        case (kind)
            K_GET: begin
                op  = OP_GET;
                pos = any_pos(len);
            end
            K_DEL: begin
                op = OP_DELETE;
                case ($urandom_range(3))
                    0: pos = '0;
                    1: pos = (len == 0) ? '0 : POS_W'(len - 1);
                    default: pos = any_pos(len);
                endcase
            end
            K_HEAD: op = OP_ADD_HEAD;
            K_TAIL: op = OP_ADD_TAIL;
            K_AT: begin
                op  = OP_ADD_AT;
                pos = POS_W'($urandom_range(0, len));
            end
            K_STRAY: begin
                case ($urandom_range(2))
                    0: op = OP_GET;
                    1: op = OP_DELETE;
                    default: op = OP_ADD_AT;
                endcase
                if (op == OP_ADD_AT && len < FULL_LEN) begin
                    pos = POS_W'($urandom_range(len + 1, FULL_LEN));
                end else begin
                    pos = POS_W'($urandom_range(len, FULL_LEN));
                end
            end
            default: begin
                case ($urandom_range(2))
                    0: op = OP_SPARE_5;
                    1: op = OP_SPARE_6;
                    default: op = OP_SPARE_7;
                endcase
            end
        endcase
    endtask

    initial begin : stimulus
        fill_phase_t      phase;
        int               hold_left;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cmd_op    = OP_GET;
        cmd_pos   = '0;
        cmd_val   = '0;
        phase     = GROW;
        hold_left = HOLD_ITEMS;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list
        issue(OP_GET, 9'd0, 32'h0);
        issue(OP_DELETE, 9'd0, 32'h0);
        issue(OP_ADD_AT, 9'd1, 32'h1234_5678);
        // build a short list with extreme values
        issue(OP_ADD_AT, 9'd0, 32'h8000_0000);
        issue(OP_ADD_HEAD, 9'd256, 32'h7fff_ffff);
        issue(OP_ADD_TAIL, 9'd0, 32'h0000_0000);
        issue(OP_ADD_TAIL, 9'd511, 32'hffff_ffff);
        issue(OP_ADD_AT, 9'd2, 32'h5555_5555);
        issue(OP_ADD_AT, 9'd5, 32'haaaa_aaaa);
        issue(OP_ADD_AT, 9'd7, 32'h0000_0001);
        issue(OP_GET, 9'd0, 32'h0);
        issue(OP_GET, 9'd5, 32'h0);
        issue(OP_GET, 9'd3, 32'h0);
        issue(OP_GET, 9'd6, 32'h0);
        issue(OP_GET, 9'd256, 32'h0);
        issue(OP_SPARE_5, 9'd256, 32'hffff_ffff);
        issue(OP_SPARE_6, 9'd0, 32'h8000_0000);
        issue(OP_SPARE_7, 9'd1, 32'h7fff_ffff);
        // delete tail, head, middle, past the end
        issue(OP_DELETE, 9'd5, 32'h0);
        issue(OP_DELETE, 9'd0, 32'h0);
        issue(OP_DELETE, 9'd2, 32'h0);
        issue(OP_DELETE, 9'd256, 32'h0);
        issue(OP_GET, 9'd2, 32'h0);

        // grow to full, try adds while full, shrink, then mix
        for (int k = 0; k < N_RANDOM; k++) begin
            case (phase)
                GROW: if (seen_len == FULL_LEN) phase = HOLD_FULL;
                HOLD_FULL: begin
                    if (hold_left == 0) phase = SHRINK;
                    else hold_left--;
                end
                SHRINK: if (seen_len <= SHRINK_LEN) phase = MIXED;
                default: ;
            endcase
            next_item(phase, op, pos, val);
            issue(op, pos, val);
        end
        start <= 1'b0;

        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("indexed_linked_list_store_core regression: pass");
        end else begin
            $display("indexed_linked_list_store_core regression: fail");
        end
        $finish;
    end

endmodule
